FILE: rtl/fsk_tone_detector_assert.svh
// ----------------------------------------------------------------------------
// fsk_tone_detector_assert.svh
// Assertion macros used by the tone detector checker.
// ----------------------------------------------------------------------------
`ifndef FSK_TONE_DETECTOR_ASSERT_SVH
`define FSK_TONE_DETECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FSKTD_ASSERT_COMB(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FSKTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fsktd_pkg.sv
// ----------------------------------------------------------------------------
// fsktd_pkg
// Types, widths, register map and codes of the FSK tone detector.
// ----------------------------------------------------------------------------
package fsktd_pkg;

    // field widths
    localparam int ADC_W   = 10;
    localparam int LEVEL_W = 10;
    localparam int COEF_W  = 7;
    localparam int SAMP_W  = 16;
    localparam int MAG_W   = 15;
    localparam int DEC_W   = 2;

    // configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // converter midscale, centered value is 11 bits signed
    localparam logic signed [ADC_W:0] MIDSCALE = 11'sd512;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ATTEN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_T1_LAG2 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_T1_LAG3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_T0_LAG2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_T0_LAG3 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LVL0    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LVL1    = 3'd6;

    // register reset values (coefficients in two's complement Q6)
    localparam logic [COEF_W-1:0]  RST_ATTEN   = 7'd51;
    localparam logic [COEF_W-1:0]  RST_T1_LAG2 = 7'h61;  // -31
    localparam logic [COEF_W-1:0]  RST_T1_LAG3 = 7'd40;
    localparam logic [COEF_W-1:0]  RST_T0_LAG2 = 7'h61;  // -31
    localparam logic [COEF_W-1:0]  RST_T0_LAG3 = 7'h58;  // -40
    localparam logic [LEVEL_W-1:0] RST_LVL0    = 10'd1023;
    localparam logic [LEVEL_W-1:0] RST_LVL1    = 10'd300;

    // decision codes
    localparam logic [DEC_W-1:0] DEC_HOLD  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_TONE0 = 2'd1;
    localparam logic [DEC_W-1:0] DEC_TONE1 = 2'd2;

    // register file contents
    typedef struct packed {
        logic [COEF_W-1:0]  atten;
        logic [COEF_W-1:0]  t1_lag2;
        logic [COEF_W-1:0]  t1_lag3;
        logic [COEF_W-1:0]  t0_lag2;
        logic [COEF_W-1:0]  t0_lag3;
        logic [LEVEL_W-1:0] lvl0;
        logic [LEVEL_W-1:0] lvl1;
    } cfg_t;

    // pipeline strobes toward the filter bank
    typedef struct packed {
        logic load;   // sample word taken into the scaling stage
        logic step;   // filter stage advances, histories shift
    } ctrl_t;

endpackage

FILE: rtl/fsktd_if.sv
// ----------------------------------------------------------------------------
// fsktd_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface fsktd_in_if;
    import fsktd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADC_W-1:0]   adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface fsktd_out_if;
    import fsktd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] out_level;
    logic [DEC_W-1:0]   decision;
    logic [MAG_W-1:0]   energy_tone0;
    logic [MAG_W-1:0]   energy_tone1;

    modport source (output valid, output out_level, output decision,
                    output energy_tone0, output energy_tone1, input ready);
    modport sink   (input valid, input out_level, input decision,
                    input energy_tone0, input energy_tone1, output ready);
endinterface

FILE: rtl/fsk_tone_detector.sv
// A sample word accepted into the scaling register moves through the filter histories
// to the result word register. Throughput: one word per cycle unless the result word
// stalls, and the ring memory is read one stage before write-back.
// Reset: rst_n clears the histories, sums, held level, ring pointer and fill flag,
// no clearing pass; ring slots not yet written count as zero.
// ----------------------------------------------------------------------------
// fsk_tone_detector
// Two-tone detector: scaled input, two recursive filters, running-mean energy
// per tone held in one ring memory, and a level decision from the means.
// ----------------------------------------------------------------------------
module fsk_tone_detector #(
    parameter int AVG_LOG2 = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fsktd_in_if.sink                      in_ch,
    fsktd_out_if.source                   out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsktd_pkg::PADDR_W-1:0] paddr,
    input  logic [fsktd_pkg::PDATA_W-1:0] pwdata,
    output logic [fsktd_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import fsktd_pkg::*;

    localparam int SUM_W = MAG_W + AVG_LOG2;
    localparam int RAM_W = 2 * MAG_W;

    cfg_t                       cfg;
    ctrl_t                      ctrl;
    logic                       advance;
    logic                       accept;

    logic                       s1_valid_reg;
    logic                       s2_valid_reg;
    logic                       out_valid_reg;
    logic [AVG_LOG2-1:0]        iss_ptr_reg;
    logic                       iss_full_reg;
    logic [AVG_LOG2-1:0]        s1_ptr_reg;
    logic                       s1_full_reg;
    logic [AVG_LOG2-1:0]        s2_ptr_reg;
    logic                       s2_full_reg;

    logic signed [SAMP_W-1:0]   y1;
    logic signed [SAMP_W-1:0]   y0;
    logic [MAG_W-1:0]           mag1;
    logic [MAG_W-1:0]           mag0;
    logic [RAM_W-1:0]           ring_rdata;
    logic [RAM_W-1:0]           ring_old;
    logic [SUM_W-1:0]           sum1_reg;
    logic [SUM_W-1:0]           sum0_reg;
    logic [SUM_W-1:0]           sum1_next;
    logic [SUM_W-1:0]           sum0_next;
    logic [MAG_W-1:0]           mean1;
    logic [MAG_W-1:0]           mean0;
    logic [LEVEL_W-1:0]         held_level_reg;
    logic [LEVEL_W-1:0]         held_level_next;
    logic [DEC_W-1:0]           dec_next;
    logic                       s2_fire;

    logic [LEVEL_W-1:0]         out_level_reg;
    logic [DEC_W-1:0]           decision_reg;
    logic [MAG_W-1:0]           energy0_reg;
    logic [MAG_W-1:0]           energy1_reg;

    // register file
    fsktd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // whole pipeline moves together unless the result word is stalled
    assign advance      = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && advance;
    assign in_ch.ready  = advance;
    assign ctrl.load    = accept;
    assign ctrl.step    = advance && s1_valid_reg;
    assign s2_fire      = advance && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // ring slot per word; the fill flag marks that every slot has been assigned to a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_ptr_reg  <= '0;
            iss_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            iss_ptr_reg <= iss_ptr_reg + 1'b1;
            if (&iss_ptr_reg)
            begin
                iss_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ptr_reg  <= iss_ptr_reg;
            s1_full_reg <= iss_full_reg;
        end
        if (advance)
        begin
            s2_ptr_reg  <= s1_ptr_reg;
            s2_full_reg <= s1_full_reg;
        end
    end

    // scaling and filters
    fsktd_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .adc_sample (in_ch.adc_sample),
        .y1         (y1),
        .y0         (y0)
    );

    // magnitudes, most negative output saturates
    always_comb
    begin
        if (y1 == {1'b1, {(SAMP_W-1){1'b0}}})
            mag1 = {MAG_W{1'b1}};
        else if (y1 < 0)
            mag1 = MAG_W'(-y1);
        else
            mag1 = MAG_W'(y1);
        if (y0 == {1'b1, {(SAMP_W-1){1'b0}}})
            mag0 = {MAG_W{1'b1}};
        else if (y0 < 0)
            mag0 = MAG_W'(-y0);
        else
            mag0 = MAG_W'(y0);
    end

    // ring: slot read as the word enters stage 2, written back as it leaves;
    // a slot is reused only a full ring later, so no forwarding is needed
    fsktd_ring_ram #(
        .ADDR_W (AVG_LOG2),
        .DATA_W (RAM_W)
    ) u_ring_ram (
        .clk   (clk),
        .we    (s2_fire),
        .waddr (s2_ptr_reg),
        .wdata ({mag0, mag1}),
        .re    (ctrl.step),
        .raddr (s1_ptr_reg),
        .rdata (ring_rdata)
    );

    assign ring_old  = s2_full_reg ? ring_rdata : '0;
    assign sum1_next = sum1_reg - SUM_W'(ring_old[MAG_W-1:0]) + SUM_W'(mag1);
    assign sum0_next = sum0_reg - SUM_W'(ring_old[RAM_W-1:MAG_W]) + SUM_W'(mag0);
    assign mean1     = sum1_next[SUM_W-1 -: MAG_W];
    assign mean0     = sum0_next[SUM_W-1 -: MAG_W];

    // level decision, tie keeps the held level
    always_comb
    begin
        held_level_next = held_level_reg;
        dec_next        = DEC_HOLD;
        if (mean0 > mean1)
        begin
            held_level_next = cfg.lvl0;
            dec_next        = DEC_TONE0;
        end
        else if (mean0 < mean1)
        begin
            held_level_next = cfg.lvl1;
            dec_next        = DEC_TONE1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum1_reg       <= '0;
            sum0_reg       <= '0;
            held_level_reg <= '0;
        end
        else if (s2_fire)
        begin
            sum1_reg       <= sum1_next;
            sum0_reg       <= sum0_next;
            held_level_reg <= held_level_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_level_reg <= held_level_next;
            decision_reg  <= dec_next;
            energy0_reg   <= mean0;
            energy1_reg   <= mean1;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_level    = out_level_reg;
    assign out_ch.decision     = decision_reg;
    assign out_ch.energy_tone0 = energy0_reg;
    assign out_ch.energy_tone1 = energy1_reg;

endmodule

FILE: rtl/fsktd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fsktd_cfg_regs
// APB-style register file: attenuation, filter weights and output levels.
// ----------------------------------------------------------------------------
module fsktd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsktd_pkg::PADDR_W-1:0] paddr,
    input  logic [fsktd_pkg::PDATA_W-1:0] pwdata,
    output logic [fsktd_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output fsktd_pkg::cfg_t               cfg
);
    import fsktd_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    // write decode, bits above a register's width dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ATTEN:   cfg_next.atten   = pwdata[COEF_W-1:0];
                REG_T1_LAG2: cfg_next.t1_lag2 = pwdata[COEF_W-1:0];
                REG_T1_LAG3: cfg_next.t1_lag3 = pwdata[COEF_W-1:0];
                REG_T0_LAG2: cfg_next.t0_lag2 = pwdata[COEF_W-1:0];
                REG_T0_LAG3: cfg_next.t0_lag3 = pwdata[COEF_W-1:0];
                REG_LVL0:    cfg_next.lvl0    = pwdata[LEVEL_W-1:0];
                REG_LVL1:    cfg_next.lvl1    = pwdata[LEVEL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.atten   <= RST_ATTEN;
            cfg_reg.t1_lag2 <= RST_T1_LAG2;
            cfg_reg.t1_lag3 <= RST_T1_LAG3;
            cfg_reg.t0_lag2 <= RST_T0_LAG2;
            cfg_reg.t0_lag3 <= RST_T0_LAG3;
            cfg_reg.lvl0    <= RST_LVL0;
            cfg_reg.lvl1    <= RST_LVL1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_ATTEN:   prdata = PDATA_W'(cfg_reg.atten);
            REG_T1_LAG2: prdata = PDATA_W'(cfg_reg.t1_lag2);
            REG_T1_LAG3: prdata = PDATA_W'(cfg_reg.t1_lag3);
            REG_T0_LAG2: prdata = PDATA_W'(cfg_reg.t0_lag2);
            REG_T0_LAG3: prdata = PDATA_W'(cfg_reg.t0_lag3);
            REG_LVL0:    prdata = PDATA_W'(cfg_reg.lvl0);
            REG_LVL1:    prdata = PDATA_W'(cfg_reg.lvl1);
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/fsktd_filter.sv
// ----------------------------------------------------------------------------
// fsktd_filter
// Input scaling and the two recursive tone filters with their histories.
// ----------------------------------------------------------------------------
module fsktd_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsktd_pkg::ctrl_t                    ctrl,
    input  fsktd_pkg::cfg_t                     cfg,
    input  logic [fsktd_pkg::ADC_W-1:0]         adc_sample,
    output logic signed [fsktd_pkg::SAMP_W-1:0] y1,
    output logic signed [fsktd_pkg::SAMP_W-1:0] y0
);
    import fsktd_pkg::*;

    localparam int X_W    = ADC_W + 7;        // centered sample << 6
    localparam int PROD_W = X_W + COEF_W + 1; // unsigned atten times x
    localparam int ACC_W  = SAMP_W + 3;

    logic signed [ADC_W:0]      centered;
    logic signed [X_W-1:0]      x_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [X_W-1:0]      x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W:0]      scaled_diff;
    logic signed [SAMP_W-1:0]   xs;
    logic signed [ACC_W-1:0]    drive1;
    logic signed [ACC_W-1:0]    drive0;
    logic signed [SAMP_W-1:0]   hist1_reg [0:2];
    logic signed [SAMP_W-1:0]   hist0_reg [0:2];
    logic signed [SAMP_W-1:0]   y1_next;
    logic signed [SAMP_W-1:0]   y0_next;

    // drive + floor(c2*h2/64) + floor(c3*h3/64), wrapped to 16 bits
    function automatic logic signed [SAMP_W-1:0] tap_sum(
        input logic signed [ACC_W-1:0]  drive,
        input logic        [COEF_W-1:0] c2,
        input logic        [COEF_W-1:0] c3,
        input logic signed [SAMP_W-1:0] h2,
        input logic signed [SAMP_W-1:0] h3
    );
        logic signed [SAMP_W+COEF_W-1:0] p2;
        logic signed [SAMP_W+COEF_W-1:0] p3;
        logic signed [ACC_W-1:0]         acc;
        p2  = $signed(c2) * h2;
        p3  = $signed(c3) * h3;
        acc = drive + ACC_W'(p2[SAMP_W+COEF_W-1:6]) + ACC_W'(p3[SAMP_W+COEF_W-1:6]);
        return acc[SAMP_W-1:0];
    endfunction

    // scaling stage: center, shift and multiply by the attenuation
    assign centered  = $signed({1'b0, adc_sample}) - MIDSCALE;
    assign x_next    = {centered, 6'b0};
    assign prod_next = $signed({1'b0, cfg.atten}) * x_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg    <= x_next;
            prod_reg <= prod_next;
        end
    end

    // x - floor(atten*x/64), wrapped
    assign scaled_diff = (ACC_W+1)'(x_reg) - (ACC_W+1)'(prod_reg[PROD_W-1:6]);
    assign xs          = scaled_diff[SAMP_W-1:0];
    assign drive1      = ACC_W'(xs);
    assign drive0      = -ACC_W'(xs);

    assign y1_next = tap_sum(drive1, cfg.t1_lag2, cfg.t1_lag3, hist1_reg[1], hist1_reg[2]);
    assign y0_next = tap_sum(drive0, cfg.t0_lag2, cfg.t0_lag3, hist0_reg[1], hist0_reg[2]);

    // histories; the newest entry is the filter output handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist1_reg[0] <= '0;
            hist1_reg[1] <= '0;
            hist1_reg[2] <= '0;
            hist0_reg[0] <= '0;
            hist0_reg[1] <= '0;
            hist0_reg[2] <= '0;
        end
        else if (ctrl.step)
        begin
            hist1_reg[0] <= y1_next;
            hist1_reg[1] <= hist1_reg[0];
            hist1_reg[2] <= hist1_reg[1];
            hist0_reg[0] <= y0_next;
            hist0_reg[1] <= hist0_reg[0];
            hist0_reg[2] <= hist0_reg[1];
        end
    end

    assign y1 = hist1_reg[0];
    assign y0 = hist0_reg[0];

endmodule

FILE: rtl/fsktd_ring_ram.sv
// ----------------------------------------------------------------------------
// fsktd_ring_ram
// Magnitude ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fsktd_ring_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 30
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fsktd_checker.sv
// ----------------------------------------------------------------------------
// fsktd_checker
// Port-level checks of the tone detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "fsk_tone_detector_assert.svh"

module fsktd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fsktd_pkg::LEVEL_W-1:0] out_level,
    input  logic [fsktd_pkg::DEC_W-1:0]   decision,
    input  logic [fsktd_pkg::MAG_W-1:0]   energy_tone0,
    input  logic [fsktd_pkg::MAG_W-1:0]   energy_tone1
);
    import fsktd_pkg::*;

    logic [LEVEL_W-1:0] last_level_reg;

    // level of the last delivered word; matches the held level after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_level_reg <= out_level;
        end
    end

    // decision agrees with the energies it reports
    `FSKTD_ASSERT_COMB(a_decision_vs_energy, out_valid, (decision == DEC_HOLD && energy_tone0 == energy_tone1) || (decision == DEC_TONE0 && energy_tone0 > energy_tone1) || (decision == DEC_TONE1 && energy_tone0 < energy_tone1), "decision does not match energies")

    // a tie repeats the level of the previous word
    `FSKTD_ASSERT_COMB(a_tie_holds_level, out_valid && decision == DEC_HOLD, out_level == last_level_reg, "tie changed the output level")

    // input is only held off by a stalled result word
    `FSKTD_ASSERT_COMB(a_ready_when_empty, !out_valid, in_ready, "input stalled with no pending result")

    // stalled result word holds
    `FSKTD_ASSERT_NEXT(a_out_stall_holds, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(decision) && $stable(energy_tone0) && $stable(energy_tone1), "stalled result word changed")

endmodule

bind fsk_tone_detector fsktd_checker u_fsktd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_level    (out_ch.out_level),
    .decision     (out_ch.decision),
    .energy_tone0 (out_ch.energy_tone0),
    .energy_tone1 (out_ch.energy_tone1)
);
